// ----- sv/spi_eeprom_page_write_sequencer_top_defines.svh -----
// Assertion macros used by the checker of the sequencer.
`ifndef SPI_EEPROM_PAGE_WRITE_SEQUENCER_TOP_DEFINES_SVH
`define SPI_EEPROM_PAGE_WRITE_SEQUENCER_TOP_DEFINES_SVH

// Plain property that must hold at every clock edge outside reset.
`define SEPWS_ASSERT(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("sepws assertion failed");

// Overlapping implication: when the antecedent holds, so must the consequent.
`define SEPWS_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sepws implication failed");

// Next-cycle implication.
`define SEPWS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sepws next-cycle implication failed");

`endif

// ----- sv/sepws_pkg.sv -----
// Package with the types, codes and result generator of the SPI EEPROM sequencer.
`timescale 1ns / 1ps
package sepws_pkg;

   // Page size of the EEPROM; must be a power of two.
   localparam int PAGE_BYTES = 32;
   localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   localparam int ADDR_W = 16;
   localparam int BYTE_W = 8;
   localparam int LEN_W  = 16;

   localparam int REQ_DATA_W = ADDR_W + BYTE_W + LEN_W;
   localparam int RSP_DATA_W = 32;

   // Request codes carried on req_tuser.
   localparam logic [2:0] REQ_WRITE_DATA   = 3'd0;
   localparam logic [2:0] REQ_READ_BLOCK   = 3'd1;
   localparam logic [2:0] REQ_READ_STATUS  = 3'd2;
   localparam logic [2:0] REQ_WRITE_STATUS = 3'd3;
   localparam logic [2:0] REQ_POLL_REPLY   = 3'd4;

   // EEPROM opcodes.
   localparam logic [7:0] CMD_WREN  = 8'h06;
   localparam logic [7:0] CMD_WRDI  = 8'h04;
   localparam logic [7:0] CMD_RDSR  = 8'h05;
   localparam logic [7:0] CMD_WRSR  = 8'h01;
   localparam logic [7:0] CMD_READ  = 8'h03;
   localparam logic [7:0] CMD_WRITE = 8'h02;

   localparam logic [7:0] BUSY_MASK_RESET = 8'h01;

   typedef enum logic [1:0] {
      OP_SEND  = 2'd0,
      OP_RECV  = 2'd1,
      OP_DESEL = 2'd2
   } spi_op_type;

   typedef enum logic {
      PHASE_IDLE = 1'b0,
      PHASE_POLL = 1'b1
   } phase_type;

   // What the back end has to emit for one accepted request.
   typedef enum logic [2:0] {
      JOB_REJECT       = 3'd0,
      JOB_POLL_BUSY    = 3'd1,
      JOB_POLL_DONE    = 3'd2,
      JOB_WRITE_BYTE   = 3'd3,
      JOB_READ_BLOCK   = 3'd4,
      JOB_READ_STATUS  = 3'd5,
      JOB_WRITE_STATUS = 3'd6
   } job_kind_type;

   typedef struct packed {
      job_kind_type        kind;
      logic                open_page;
      logic                close_page;
      logic [ADDR_W-1:0]   address;
      logic [BYTE_W-1:0]   payload;
      logic [LEN_W-1:0]    length;
   } job_type;

   typedef struct packed {
      spi_op_type          spi_op;
      logic [BYTE_W-1:0]   tx_byte;
      logic [LEN_W-1:0]    rx_count;
      logic                deselect_after;
      logic                rejected;
      logic                last;
   } result_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic result_type make_send(logic [BYTE_W-1:0] data, logic desel);
      result_type r;
      r                = '0;
      r.spi_op         = OP_SEND;
      r.tx_byte        = data;
      r.deselect_after = desel;
      return r;
   endfunction

   function automatic result_type make_recv(logic [LEN_W-1:0] count, logic desel);
      result_type r;
      r                = '0;
      r.spi_op         = OP_RECV;
      r.rx_count       = count;
      r.deselect_after = desel;
      return r;
   endfunction

   // Result number 'step' of a job. A write byte on a closed page starts at
   // the write-enable; on an open page it starts at the data byte.
   function automatic result_type job_result(job_type job, logic [2:0] step);
      result_type r;
      logic [2:0] wstep;
      r     = '0;
      wstep = job.open_page ? step : 3'(step + 3'd4);
      case (job.kind)
         JOB_REJECT: begin
            r.spi_op   = OP_DESEL;
            r.rejected = 1'b1;
            r.last     = 1'b1;
         end
         JOB_POLL_BUSY: begin
            r      = make_recv(LEN_W'(1), 1'b0);
            r.last = 1'b1;
         end
         JOB_POLL_DONE: begin
            r.spi_op         = OP_DESEL;
            r.deselect_after = 1'b1;
            r.last           = 1'b1;
         end
         JOB_WRITE_BYTE: begin
            case (wstep)
               3'd0: r = make_send(CMD_WREN, 1'b1);
               3'd1: r = make_send(CMD_WRITE, 1'b0);
               3'd2: r = make_send(job.address[ADDR_W-1:BYTE_W], 1'b0);
               3'd3: r = make_send(job.address[BYTE_W-1:0], 1'b0);
               3'd4: begin
                  r      = make_send(job.payload, job.close_page);
                  r.last = !job.close_page;
               end
               3'd5: r = make_send(CMD_WRDI, 1'b1);
               3'd6: r = make_send(CMD_RDSR, 1'b0);
               default: begin
                  r      = make_recv(LEN_W'(1), 1'b0);
                  r.last = 1'b1;
               end
            endcase
         end
         JOB_READ_BLOCK: begin
            case (step)
               3'd0: r = make_send(CMD_READ, 1'b0);
               3'd1: r = make_send(job.address[ADDR_W-1:BYTE_W], 1'b0);
               3'd2: r = make_send(job.address[BYTE_W-1:0], 1'b0);
               default: begin
                  if (job.length != '0) begin
                     r = make_recv(job.length, 1'b1);
                  end else begin
                     r.spi_op         = OP_DESEL;
                     r.deselect_after = 1'b1;
                  end
                  r.last = 1'b1;
               end
            endcase
         end
         JOB_READ_STATUS: begin
            if (step == 3'd0) begin
               r = make_send(CMD_RDSR, 1'b0);
            end else begin
               r      = make_recv(LEN_W'(1), 1'b1);
               r.last = 1'b1;
            end
         end
         JOB_WRITE_STATUS: begin
            case (step)
               3'd0: r = make_send(CMD_WREN, 1'b1);
               3'd1: r = make_send(CMD_WRSR, 1'b0);
               3'd2: r = make_send(job.payload, 1'b1);
               default: begin
                  r      = make_send(CMD_WRDI, 1'b1);
                  r.last = 1'b1;
               end
            endcase
         end
         default: begin
            r.spi_op   = OP_DESEL;
            r.rejected = 1'b1;
            r.last     = 1'b1;
         end
      endcase
      return r;
   endfunction

endpackage

// ----- sv/sepws_front.sv -----
// Front end: accepts requests, tracks page and polling state, and issues jobs.
`timescale 1ns / 1ps
module sepws_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sepws_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]                       req_tuser,
   input  logic                             req_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [7:0]                       csr_data,
   input  sepws_pkg::queue_status_type      q_status,
   output logic                             job_push,
   output sepws_pkg::job_type               job
);
   import sepws_pkg::*;

   logic [BYTE_W-1:0] busy_mask_ff;
   phase_type         phase_ff, phase_in;
   logic [ADDR_W-1:0] next_addr_ff, next_addr_in;
   logic              page_open_ff, page_open_in;
   logic              block_cont_ff, block_cont_in;

   logic [ADDR_W-1:0] start_address;
   logic [BYTE_W-1:0] payload_byte;
   logic [LEN_W-1:0]  read_length;
   logic              accept;
   logic              reject;
   logic              still_busy;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] wr_next;
   logic              wr_close;

   assign start_address = req_tdata[ADDR_W-1:0];
   assign payload_byte  = req_tdata[ADDR_W+BYTE_W-1:ADDR_W];
   assign read_length   = req_tdata[REQ_DATA_W-1:ADDR_W+BYTE_W];

   assign req_tready = !q_status.full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;

   assign reject     = (phase_ff == PHASE_POLL) ||
                       (page_open_ff && (req_tuser != REQ_WRITE_DATA));
   assign still_busy = (payload_byte & busy_mask_ff) != '0;

   // An open page or continued block uses the tracked address, else the request.
   assign wr_addr  = (page_open_ff || block_cont_ff) ? next_addr_ff : start_address;
   assign wr_next  = ADDR_W'(wr_addr + ADDR_W'(1));
   assign wr_close = req_tlast || (wr_next[PAGE_BITS-1:0] == '0);

   always_comb begin
      phase_in      = phase_ff;
      next_addr_in  = next_addr_ff;
      page_open_in  = page_open_ff;
      block_cont_in = block_cont_ff;
      if (accept) begin
         if (req_tuser == REQ_POLL_REPLY) begin
            if (phase_ff == PHASE_POLL && !still_busy) begin
               phase_in = PHASE_IDLE;
            end
         end else if (req_tuser == REQ_WRITE_DATA && !reject) begin
            next_addr_in = wr_next;
            if (wr_close) begin
               page_open_in  = 1'b0;
               block_cont_in = !req_tlast;
               phase_in      = PHASE_POLL;
            end else begin
               page_open_in  = 1'b1;
            end
         end
      end
   end

   always_comb begin
      job_push       = 1'b0;
      job.kind       = JOB_REJECT;
      job.open_page  = !page_open_ff;
      job.close_page = wr_close;
      job.address    = (req_tuser == REQ_WRITE_DATA) ? wr_addr : start_address;
      job.payload    = payload_byte;
      job.length     = read_length;
      if (req_tuser == REQ_POLL_REPLY) begin
         job_push = accept && (phase_ff == PHASE_POLL);
         job.kind = still_busy ? JOB_POLL_BUSY : JOB_POLL_DONE;
      end else if (req_tuser inside {[REQ_WRITE_DATA:REQ_WRITE_STATUS]}) begin
         job_push = accept;
         if (reject) begin
            job.kind = JOB_REJECT;
         end else begin
            case (req_tuser)
               REQ_WRITE_DATA:  job.kind = JOB_WRITE_BYTE;
               REQ_READ_BLOCK:  job.kind = JOB_READ_BLOCK;
               REQ_READ_STATUS: job.kind = JOB_READ_STATUS;
               default:         job.kind = JOB_WRITE_STATUS;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_mask_ff  <= BUSY_MASK_RESET;
         phase_ff      <= PHASE_IDLE;
         next_addr_ff  <= '0;
         page_open_ff  <= 1'b0;
         block_cont_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            busy_mask_ff <= csr_data;
         end
         phase_ff      <= phase_in;
         next_addr_ff  <= next_addr_in;
         page_open_ff  <= page_open_in;
         block_cont_ff <= block_cont_in;
      end
   end

endmodule

// ----- sv/sepws_queue.sv -----
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps
module sepws_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  sepws_pkg::job_type          push_job,
   input  logic                        pop,
   output sepws_pkg::job_type          head_job,
   output sepws_pkg::queue_status_type status
);
   import sepws_pkg::*;

   job_type                   slots_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;

   assign status.full  = (count_ff == (QUEUE_PTR_BITS+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QUEUE_PTR_BITS'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_PTR_BITS'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = (QUEUE_PTR_BITS+1)'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = (QUEUE_PTR_BITS+1)'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- sv/sepws_back.sv -----
// Back end: puts each job's SPI operations into an output register, one per clock if free.
`timescale 1ns / 1ps
module sepws_back (
   input  logic                             clock,
   input  logic                             reset,
   input  sepws_pkg::job_type               head_job,
   input  sepws_pkg::queue_status_type      q_status,
   output logic                             job_pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sepws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast
);
   import sepws_pkg::*;

   logic [2:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   result_type rsp_ff;
   result_type gen;
   logic       load;

   assign gen     = job_result(head_job, step_ff);
   assign load    = !q_status.empty && (!valid_ff || rsp_tready);
   assign job_pop = load && gen.last;

   always_comb begin
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         step_in  = gen.last ? 3'd0 : 3'(step_ff + 3'd1);
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= gen;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {4'b0000, rsp_ff.rejected, rsp_ff.deselect_after,
                        rsp_ff.rx_count, rsp_ff.tx_byte, rsp_ff.spi_op};

endmodule

// ----- sv/spi_eeprom_page_write_sequencer_top.sv -----
// Top level of the SPI EEPROM page-write sequencer.
`timescale 1ns / 1ps
// This block turns host requests into SPI operations for a serial EEPROM with
// 16-bit addressing. Each accepted request transaction causes between zero and
// eight result transactions, the final one marked by rsp_tlast; poll replies
// outside a poll and unused request codes cause none. The front end takes one
// request per clock as long as its four-entry job queue has room, so requests
// keep flowing while the back end is still busy. The back end emits exactly one
// result per clock when the output register is free and a job is queued. A
// request gives one result for a data byte in the middle of a page and up to
// eight for a byte that opens and closes a page. The first result of a request
// passes through the job queue and then the output register before it is offered
// on rsp_tvalid. The busy mask on the csr_
// channel is taken at any time but should only be changed while idle. After a
// page closes, the host must feed poll replies (the status byte read back) until
// none of the busy bits are set; other requests in that time are answered with
// a single rejected result that must not be executed.
module spi_eeprom_page_write_sequencer_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_address [15:0], payload_byte [23:16], read_length [39:24]
   input  logic [sepws_pkg::REQ_DATA_W-1:0] req_tdata,
   // req_type [2:0]
   input  logic [2:0]                       req_tuser,
   // final_byte
   input  logic                             req_tlast,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // spi_op [1:0], tx_byte [9:2], rx_count [25:10], deselect_after [26],
   // rejected [27], zero [31:28]
   output logic [sepws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // last
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   // busy_bit_mask
   input  logic [7:0]                       csr_data
);
   import sepws_pkg::*;

   queue_status_type q_status;
   job_type          push_job;
   job_type          head_job;
   logic             job_push;
   logic             job_pop;

   // Classification and the page and polling state live in the front end, so
   // each request sees the state as updated by the one before it.
   sepws_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .q_status   (q_status),
      .job_push   (job_push),
      .job        (push_job)
   );

   // The queue lets the front end run ahead of the back end by up to four jobs.
   sepws_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (push_job),
      .pop      (job_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // The back end walks each job step by step into the output register.
   sepws_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .q_status   (q_status),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- sv/sepws_checker.sv -----
// Port-level checker for the sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "spi_eeprom_page_write_sequencer_top_defines.svh"
module sepws_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [sepws_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);
   import sepws_pkg::*;

   logic rsp_stall;
   logic rsp_is_reject;
   logic reject_shape_ok;
   logic rsp_not_send;
   logic tx_clear;

   assign rsp_stall       = rsp_tvalid && !rsp_tready;
   assign rsp_is_reject   = rsp_tvalid && rsp_tdata[27];
   assign reject_shape_ok = rsp_tlast && (rsp_tdata[1:0] == OP_DESEL) &&
                            !rsp_tdata[26] && (rsp_tdata[25:2] == '0);
   assign rsp_not_send    = rsp_tvalid && (rsp_tdata[1:0] != OP_SEND);
   assign tx_clear        = (rsp_tdata[9:2] == '0);

   // A stalled result keeps its contents.
   `SEPWS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable({rsp_tlast, rsp_tdata}))

   // A rejected result is a lone, inert deselect code that ends its transaction group.
   `SEPWS_ASSERT_IMPL(a_reject_shape, clock, reset, rsp_is_reject, reject_shape_ok)

   // The byte field is only used by send operations.
   `SEPWS_ASSERT_IMPL(a_tx_only_send, clock, reset, rsp_not_send, tx_clear)

   // Nothing is offered right after reset.
   `SEPWS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_tvalid)

endmodule

bind spi_eeprom_page_write_sequencer_top sepws_checker u_sepws_checker (.*);
